// ----- rtl/core/frame_contrast_stretch_bin2x2_defines.svh -----
// Assertion macros shared by the core; clock i_clk, reset i_rst_n.
`ifndef FRAME_CONTRAST_STRETCH_BIN2X2_DEFINES_SVH
`define FRAME_CONTRAST_STRETCH_BIN2X2_DEFINES_SVH

// Same-cycle implication.
`define FCSB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FCSB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/fcsb_pkg.sv -----
package fcsb_pkg;

    localparam int SAMPLE_W = 16;
    localparam int VAL_W    = 18;
    localparam int PIX_W    = 8;
    localparam int QUOT_W   = 8;
    localparam int NUM_W    = VAL_W + QUOT_W;
    localparam int STEP_CW  = 4;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_ADDR,
        S_LD_RD,
        S_LD_WR,
        S_LT_B,
        S_LT_W,
        S_LT_FIN,
        S_FT_CHK,
        S_FT_RD,
        S_FT_DIV,
        S_FT_OUT
    } t_state;

    typedef enum logic [2:0] {
        REG_WIDTH,
        REG_HEIGHT,
        REG_SHIFT,
        REG_BITS,
        REG_SUM,
        REG_AUTO,
        REG_BLACK,
        REG_WHITE
    } t_reg_idx;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] num;
        logic [VAL_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

endpackage

// ----- rtl/core/frame_contrast_stretch_bin2x2.sv -----
// Load beat: busy through address, store read and write back;
//   the last sample of a frame then also latches the stretch limits.
// Fetch beat: check, store read, 8-step divider, then the result strobe;
//   a pixel at or beyond a limit skips the divider.
// One item at a time (taken only when idle); a fetch with no pixel due has no strobe.
// Reset (i_rst_n low, synchronous) presets counters, min/max, limits and config regs.
`include "frame_contrast_stretch_bin2x2_defines.svh"
module frame_contrast_stretch_bin2x2 #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_opcode,
    input  logic [fcsb_pkg::SAMPLE_W-1:0]  i_raw_sample,
    output logic                           o_result_valid,
    output logic [fcsb_pkg::PIX_W-1:0]     o_pixel,
    output logic                           o_last_pixel,
    output logic                           o_saturated,
    output logic [fcsb_pkg::VAL_W-1:0]     o_stretch_low,
    output logic [fcsb_pkg::VAL_W-1:0]     o_stretch_high,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [4:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import fcsb_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int XW    = $clog2(MAX_WIDTH + 1);
    localparam int YW    = $clog2(MAX_HEIGHT + 1);
    localparam int PW    = 35;

    // ---------------- configuration registers ----------------
    logic [9:0]  r_frame_width;
    logic [9:0]  r_frame_height;
    logic [3:0]  r_sample_shift;
    logic [4:0]  r_significant_bits;
    logic        r_sum_2x2;
    logic        r_auto_stretch;
    logic [16:0] r_black_point;
    logic [16:0] r_white_point;

    logic     cfg_wr;
    t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width      <= 10'd512;
            r_frame_height     <= 10'd512;
            r_sample_shift     <= 4'd0;
            r_significant_bits <= 5'd16;
            r_sum_2x2          <= 1'b0;
            r_auto_stretch     <= 1'b1;
            r_black_point      <= 17'd0;
            r_white_point      <= 17'd65536;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_WIDTH:  r_frame_width      <= pwdata[9:0];
                REG_HEIGHT: r_frame_height     <= pwdata[9:0];
                REG_SHIFT:  r_sample_shift     <= pwdata[3:0];
                REG_BITS:   r_significant_bits <= pwdata[4:0];
                REG_SUM:    r_sum_2x2          <= pwdata[0];
                REG_AUTO:   r_auto_stretch     <= pwdata[0];
                REG_BLACK:  r_black_point      <= pwdata[16:0];
                REG_WHITE:  r_white_point      <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_WIDTH:  prdata = 32'(r_frame_width);
            REG_HEIGHT: prdata = 32'(r_frame_height);
            REG_SHIFT:  prdata = 32'(r_sample_shift);
            REG_BITS:   prdata = 32'(r_significant_bits);
            REG_SUM:    prdata = 32'(r_sum_2x2);
            REG_AUTO:   prdata = 32'(r_auto_stretch);
            REG_BLACK:  prdata = 32'(r_black_point);
            REG_WHITE:  prdata = 32'(r_white_point);
            default:    prdata = '0;
        endcase
    end

    // ---------------- effective geometry ----------------
    logic [XW-1:0] w;
    logic [YW-1:0] h;
    logic          bin;
    logic [XW-1:0] bw;
    logic [YW-1:0] bh;
    logic [CW-1:0] out_count;

    always_comb begin
        if (r_frame_width == '0) begin
            w = XW'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w = XW'(MAX_WIDTH);
        end else begin
            w = XW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h = YW'(1);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            h = YW'(MAX_HEIGHT);
        end else begin
            h = YW'(r_frame_height);
        end
    end

    assign bin       = r_sum_2x2 && (w >= XW'(2)) && (h >= YW'(2));
    assign bw        = w >> 1;
    assign bh        = h >> 1;
    assign out_count = bin ? CW'(CW'(bw) * CW'(bh)) : CW'(CW'(w) * CW'(h));

    // ---------------- state ----------------
    t_state r_state, n_state;

    logic [XW-1:0]    r_col;
    logic [YW-1:0]    r_row;
    logic [CW-1:0]    r_ri;
    logic [VAL_W-1:0] r_min, r_max;
    logic [VAL_W-1:0] r_limit_low, r_limit_high;
    logic             r_sat;

    // payload
    logic [VAL_W-1:0] r_v;
    logic [AW-1:0]    r_idx;
    logic             r_inblk;
    logic             r_first;
    logic             r_close;
    logic [PW-1:0]    r_prod;
    logic [VAL_W-1:0] r_lo_man;
    logic             r_last;
    logic [PIX_W-1:0] r_pixel;

    logic accept;
    assign accept = start && !busy;

    // sample preparation at accept: frame restart and column wrap
    logic [XW-1:0] p_col;
    logic [YW-1:0] p_row;
    logic          p_clr, p_wrap;

    always_comb begin
        p_clr = r_row >= h;
        p_col = p_clr ? '0 : r_col;
        p_row = p_clr ? '0 : r_row;
        if (p_col >= w) begin
            p_col = '0;
            p_row = p_row + 1'b1;
        end
        p_wrap = p_row >= h;
        if (p_wrap) begin
            p_row = '0;
        end
    end

    // store address of the current sample
    logic [CW-1:0] ld_idx;
    logic          ld_inblk;

    always_comb begin
        if (bin) begin
            ld_idx   = CW'(CW'(r_row >> 1) * CW'(bw)) + CW'(r_col >> 1);
            ld_inblk = ((r_row >> 1) < bh) && ((r_col >> 1) < bw);
        end else begin
            ld_idx   = CW'(CW'(r_row) * CW'(w)) + CW'(r_col);
            ld_inblk = 1'b1;
        end
    end

    // store
    logic [VAL_W-1:0] st_rdata;
    logic [VAL_W-1:0] st_wdata;
    logic [AW-1:0]    st_raddr;
    logic             st_we;

    assign st_we    = (r_state == S_LD_WR) && r_inblk;
    assign st_wdata = r_first ? r_v : VAL_W'(st_rdata + r_v);
    assign st_raddr = (r_state == S_FT_CHK) ? r_ri[AW-1:0] : r_idx;

    fcsb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_idx),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // counters after a sample
    logic [XW-1:0] a_col;
    logic [YW-1:0] a_row;

    always_comb begin
        a_col = r_col + 1'b1;
        a_row = r_row;
        if (a_col >= w) begin
            a_col = '0;
            a_row = r_row + 1'b1;
        end
    end

    // limit latching
    logic [4:0]       bits_eff;
    logic [VAL_W:0]   full19;
    logic [VAL_W-1:0] full;
    logic [16:0]      bp_sat, wp_sat;
    logic [VAL_W:0]   hi_man, lo_p1, min_p1;

    always_comb begin
        if (r_significant_bits == '0) begin
            bits_eff = 5'd1;
        end else if (r_significant_bits > 5'd16) begin
            bits_eff = 5'd16;
        end else begin
            bits_eff = r_significant_bits;
        end
    end

    assign full19 = ((VAL_W + 1)'(1) << bits_eff) - (VAL_W + 1)'(1);
    assign full   = bin ? VAL_W'(full19 << 2) : VAL_W'(full19);
    assign bp_sat = (r_black_point > 17'd65536) ? 17'd65536 : r_black_point;
    assign wp_sat = (r_white_point > 17'd65536) ? 17'd65536 : r_white_point;
    assign hi_man = r_prod[VAL_W+16:16];
    assign lo_p1  = {1'b0, r_lo_man} + 1'b1;
    assign min_p1 = {1'b0, r_min} + 1'b1;

    // fetch checks and divider
    logic             ft_ok;
    logic [VAL_W-1:0] ft_n, ft_d;
    logic             ft_zero, ft_full;
    t_div_req         div_req;
    t_div_rsp         div_rsp;

    assign ft_ok   = (r_row >= h) && (r_ri < out_count);
    assign ft_zero = (st_rdata <= r_limit_low) || (r_limit_high <= r_limit_low);
    assign ft_n    = st_rdata - r_limit_low;
    assign ft_d    = r_limit_high - r_limit_low;
    assign ft_full = ft_n >= ft_d;

    assign div_req.start = (r_state == S_FT_RD) && !ft_zero && !ft_full;
    assign div_req.num   = ft_n;
    assign div_req.den   = ft_d;

    fcsb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_opcode == OP_FETCH) ? S_FT_CHK : S_LD_ADDR;
                end
            end
            S_LD_ADDR: n_state = S_LD_RD;
            S_LD_RD:   n_state = S_LD_WR;
            S_LD_WR:   n_state = (a_row >= h) ? S_LT_B : S_IDLE;
            S_LT_B:    n_state = S_LT_W;
            S_LT_W:    n_state = S_LT_FIN;
            S_LT_FIN:  n_state = S_IDLE;
            S_FT_CHK:  n_state = ft_ok ? S_FT_RD : S_IDLE;
            S_FT_RD:   n_state = (ft_zero || ft_full) ? S_FT_OUT : S_FT_DIV;
            S_FT_DIV:  n_state = div_rsp.done ? S_FT_OUT : S_FT_DIV;
            S_FT_OUT:  n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_ri         <= '0;
            r_min        <= '1;
            r_max        <= '0;
            r_limit_low  <= '0;
            r_limit_high <= VAL_W'(1);
            r_sat        <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_opcode == OP_LOAD)) begin
                        r_col <= p_col;
                        r_row <= p_row;
                        if (p_clr) begin
                            r_ri <= '0;
                        end
                        if (p_clr || p_wrap) begin
                            r_min <= '1;
                            r_max <= '0;
                        end
                    end
                end
                S_LD_WR: begin
                    if (r_inblk && r_close) begin
                        if (st_wdata < r_min) begin
                            r_min <= st_wdata;
                        end
                        if (st_wdata > r_max) begin
                            r_max <= st_wdata;
                        end
                    end
                    r_col <= a_col;
                    r_row <= a_row;
                end
                S_LT_FIN: begin
                    r_sat <= r_max >= full;
                    if (r_auto_stretch) begin
                        r_limit_low  <= r_min;
                        r_limit_high <= ({1'b0, r_max} > min_p1) ? r_max : VAL_W'(min_p1);
                    end else begin
                        r_limit_low  <= r_lo_man;
                        r_limit_high <= (hi_man < lo_p1) ? VAL_W'(lo_p1) : VAL_W'(hi_man);
                    end
                end
                S_FT_CHK: begin
                    if (ft_ok) begin
                        r_ri <= r_ri + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_v <= VAL_W'(i_raw_sample >> r_sample_shift);
            end
            S_LD_ADDR: begin
                r_idx   <= ld_idx[AW-1:0];
                r_inblk <= ld_inblk;
                r_first <= !bin || (!r_row[0] && !r_col[0]);
                r_close <= !bin || (r_row[0] && r_col[0]);
            end
            S_LT_B: begin
                r_prod <= PW'(bp_sat) * PW'(full);
            end
            S_LT_W: begin
                r_lo_man <= hi_man[VAL_W-1:0];
                r_prod   <= PW'(wp_sat) * PW'(full);
            end
            S_FT_CHK: begin
                r_last <= (r_ri + 1'b1) == out_count;
            end
            S_FT_RD: begin
                r_pixel <= ft_zero ? '0 : '1;
            end
            S_FT_DIV: begin
                if (div_rsp.done) begin
                    r_pixel <= div_rsp.quot;
                end
            end
            default: ;
        endcase
    end

    assign busy           = r_state != S_IDLE;
    assign o_result_valid = r_state == S_FT_OUT;
    assign o_pixel        = r_pixel;
    assign o_last_pixel   = r_last;
    assign o_saturated    = r_sat;
    assign o_stretch_low  = r_limit_low;
    assign o_stretch_high = r_limit_high;

    `FCSB_ASSERT_IMP(a_strobe_busy, o_result_valid, busy, "result beat outside a busy item")
    `FCSB_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
    `FCSB_ASSERT_IMP(a_div_state, div_rsp.done, r_state == S_FT_DIV, "divider done outside fetch")
    `FCSB_ASSERT_IMP(a_we_state, st_we, r_state == S_LD_WR, "store write outside write back")

endmodule

// ----- rtl/core/fcsb_store.sv -----
module fcsb_store #(
    parameter int DEPTH = 262144,
    parameter int AW    = 18
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [fcsb_pkg::VAL_W-1:0]  i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [fcsb_pkg::VAL_W-1:0]  o_rdata
);
    import fcsb_pkg::*;

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/fcsb_div.sv -----
module fcsb_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fcsb_pkg::t_div_req i_req,
    output fcsb_pkg::t_div_rsp o_rsp
);
    import fcsb_pkg::*;

    // num < den, so num*255/den fits in QUOT_W bits: one quotient bit per cycle
    logic [NUM_W-1:0]   prod;
    logic [VAL_W:0]     trial;
    logic               ge;
    logic [VAL_W-1:0]   r_rem;
    logic [VAL_W-1:0]   r_den;
    logic [QUOT_W-1:0]  r_low;
    logic [QUOT_W-1:0]  r_q;
    logic [STEP_CW-1:0] r_cnt;
    logic               r_busy;
    logic               r_done;

    assign prod  = {i_req.num, {QUOT_W{1'b0}}} - NUM_W'(i_req.num);
    assign trial = {r_rem, r_low[QUOT_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_CW'(QUOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= prod[NUM_W-1:QUOT_W];
            r_low <= prod[QUOT_W-1:0];
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= ge ? VAL_W'(trial - {1'b0, r_den}) : trial[VAL_W-1:0];
            r_low <= {r_low[QUOT_W-2:0], 1'b0};
            r_q   <= {r_q[QUOT_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

// ----- tb/sv/tb_frame_contrast_stretch_bin2x2.sv -----
`timescale 1ns / 1ps

module tb_frame_contrast_stretch_bin2x2;
    import fcsb_pkg::*;

    localparam int STORE_DEPTH = 512 * 512;
    localparam int MAX_DIM     = 512;
    localparam int WD_LIMIT    = 4000;
    localparam int SETTLE_CYC  = 20;   // margin after the core goes idle
    localparam int TARGET      = 1600;

    // one pending command beat
    typedef struct {
        logic                op;
        logic [SAMPLE_W-1:0] raw;
    } cmd_t;

    // one expected output pixel
    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             last;
        logic             sat;
        logic [VAL_W-1:0] lo;
        logic [VAL_W-1:0] hi;
    } pix_exp_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_opcode;
    logic [SAMPLE_W-1:0] i_raw_sample;
    logic                o_result_valid;
    logic [PIX_W-1:0]    o_pixel;
    logic                o_last_pixel;
    logic                o_saturated;
    logic [VAL_W-1:0]    o_stretch_low;
    logic [VAL_W-1:0]    o_stretch_high;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [4:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    frame_contrast_stretch_bin2x2 dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_raw_sample   (i_raw_sample),
        .o_result_valid (o_result_valid),
        .o_pixel        (o_pixel),
        .o_last_pixel   (o_last_pixel),
        .o_saturated    (o_saturated),
        .o_stretch_low  (o_stretch_low),
        .o_stretch_high (o_stretch_high),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // 20 ns clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    cmd_t     cmd_q[$];      // beats waiting for the driver
    pix_exp_t pix_exp_q[$];  // pixels the block still owes us
    int       fail_count = 0;
    int       items_sent = 0;
    bit       gaps_on = 1'b1; // per-phase: random idle on the command side

    // ---------------------------------------------------------------------
    // Stretch predictor: own copy of the frame store, counters and limits.
    // ---------------------------------------------------------------------
    bit [VAL_W-1:0] frame_mem [STORE_DEPTH];
    bit             mem_valid [STORE_DEPTH];
    int unsigned    col_cnt, row_cnt, rd_ptr;
    int unsigned    run_min, run_max, lim_lo, lim_hi;
    bit             sat_flag;

    // register shadow
    int unsigned    r_width, r_height, r_shift, r_bits, r_sum, r_auto, r_black, r_white;

    function automatic int unsigned eff_w();
        if (r_width == 0) return 1;
        return (r_width > MAX_DIM) ? MAX_DIM : r_width;
    endfunction

    function automatic int unsigned eff_h();
        if (r_height == 0) return 1;
        return (r_height > MAX_DIM) ? MAX_DIM : r_height;
    endfunction

    function automatic bit binned();
        return r_sum != 0 && eff_w() >= 2 && eff_h() >= 2;
    endfunction

    function automatic int unsigned out_pixels();
        if (binned()) return (eff_w() >> 1) * (eff_h() >> 1);
        return eff_w() * eff_h();
    endfunction

    function automatic bit frame_ready();
        return row_cnt >= eff_h();
    endfunction

    // latch limits and saturation at the last sample of a frame
    task automatic latch_stretch();
        int unsigned bits, full, bp, wp, lo, hi;
        bits = r_bits;
        if (bits == 0) bits = 1;
        if (bits > 16) bits = 16;
        full = (32'd1 << bits) - 1;
        if (binned()) full = full * 4;
        sat_flag = (run_max >= full);
        if (r_auto != 0) begin
            lo = run_min;
            hi = (run_max > run_min + 1) ? run_max : run_min + 1;
        end else begin
            bp = (r_black > 65536) ? 65536 : r_black;
            wp = (r_white > 65536) ? 65536 : r_white;
            lo = int'((longint'(bp) * full) >> 16);
            hi = int'((longint'(wp) * full) >> 16);
            if (hi < lo + 1) hi = lo + 1;
        end
        lim_lo = lo & 32'h3FFFF;
        lim_hi = hi & 32'h3FFFF;
    endtask

    task automatic track_range(input int unsigned v);
        if (v < run_min) run_min = v;
        if (v > run_max) run_max = v;
    endtask

    task automatic predict_load(input logic [SAMPLE_W-1:0] raw);
        int unsigned w, h, v, idx, bw, bh;
        w = eff_w();
        h = eff_h();
        v = 32'(raw) >> r_shift;
        // a load on a complete frame opens a new one
        if (row_cnt >= h) begin
            row_cnt = 0; col_cnt = 0; rd_ptr = 0;
            run_min = 32'h3FFFF; run_max = 0;
        end
        // column past a (possibly shrunk) width wraps
        if (col_cnt >= w) begin
            col_cnt = 0; row_cnt++;
        end
        if (row_cnt >= h) begin
            row_cnt = 0;
            run_min = 32'h3FFFF; run_max = 0;
        end
        if (binned()) begin
            bw = w >> 1;
            bh = h >> 1;
            if ((row_cnt >> 1) < bh && (col_cnt >> 1) < bw) begin
                idx = (row_cnt >> 1) * bw + (col_cnt >> 1);
                if (row_cnt[0] == 0 && col_cnt[0] == 0) frame_mem[idx] = v;
                else frame_mem[idx] = (frame_mem[idx] + v) & 32'h3FFFF;
                mem_valid[idx] = 1'b1;
                // block sum is complete at its lower-right sample
                if (row_cnt[0] && col_cnt[0]) track_range(frame_mem[idx]);
            end
            // odd trailing row or column falls outside every block
        end else begin
            idx = row_cnt * w + col_cnt;
            if (idx < STORE_DEPTH) begin
                frame_mem[idx] = v;
                mem_valid[idx] = 1'b1;
                track_range(v);
            end
        end
        col_cnt++;
        if (col_cnt >= w) begin
            col_cnt = 0; row_cnt++;
        end
        if (row_cnt >= h) latch_stretch();
    endtask

    // fetch: too early or past the last pixel gives nothing
    task automatic predict_fetch();
        int unsigned cnt, v;
        longint      q;
        pix_exp_t    e;
        if (!frame_ready()) return;
        cnt = out_pixels();
        if (rd_ptr >= cnt) return;
        v = frame_mem[rd_ptr];
        if (v <= lim_lo || lim_hi <= lim_lo) begin
            e.pix = '0;
        end else begin
            q = (longint'(v - lim_lo) * 255) / longint'(lim_hi - lim_lo);
            e.pix = (q > 255) ? 8'd255 : PIX_W'(q);
        end
        e.last = (rd_ptr + 1 == cnt);
        e.sat  = sat_flag;
        e.lo   = VAL_W'(lim_lo);
        e.hi   = VAL_W'(lim_hi);
        pix_exp_q.push_back(e);
        rd_ptr = (rd_ptr + 1) & 32'h3FFFF;
    endtask

    // queue a beat and predict it; never fetch a store entry not yet written
    task automatic send(input logic op, input logic [SAMPLE_W-1:0] raw);
        cmd_t c;
        if (op == OP_FETCH && frame_ready() && rd_ptr < out_pixels() && !mem_valid[rd_ptr])
            return;
        c.op  = op;
        c.raw = raw;
        cmd_q.push_back(c);
        items_sent++;
        if (op == OP_LOAD) predict_load(raw);
        else predict_fetch();
    endtask

    // nothing queued, nothing owed, and the core has settled
    task automatic wait_quiet();
        while (cmd_q.size() != 0 || pix_exp_q.size() != 0 || busy)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // APB write: setup then access; pready is tied high by the core
    task automatic reg_write(input t_reg_idx idx, input int unsigned value);
        wait_quiet();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WIDTH:  r_width  = value & 32'h3FF;
            REG_HEIGHT: r_height = value & 32'h3FF;
            REG_SHIFT:  r_shift  = value & 32'hF;
            REG_BITS:   r_bits   = value & 32'h1F;
            REG_SUM:    r_sum    = value & 32'h1;
            REG_AUTO:   r_auto   = value & 32'h1;
            REG_BLACK:  r_black  = value & 32'h1FFFF;
            REG_WHITE:  r_white  = value & 32'h1FFFF;
            default: ;
        endcase
    endtask

    // raw sample styles: full random, narrow band, flat, rails
    function automatic logic [SAMPLE_W-1:0] pick_sample(input int style, input int unsigned base);
        int unsigned r;
        case (style)
            0: r = $urandom_range(0, 65535);
            1: begin
                r = base + $urandom_range(0, 255);
                if (r > 65535) r = 65535;
            end
            2: r = base;
            default: r = $urandom_range(0, 1) ? 65535 : 0;
        endcase
        return SAMPLE_W'(r);
    endfunction

    task automatic pick_point(input t_reg_idx idx);
        int unsigned sel, v;
        sel = $urandom_range(0, 9);
        if (sel == 0) v = 0;
        else if (sel == 1) v = 65536;
        else if (sel == 2) v = $urandom_range(65537, 131071);
        else v = $urandom_range(0, 65536);
        reg_write(idx, v);
    endtask

    // point, shift, bits and mode settings that may change at any time
    task automatic random_levels();
        int unsigned b;
        reg_write(REG_SHIFT, $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0);
        b = $urandom_range(0, 9);
        if (b == 0) reg_write(REG_BITS, $urandom_range(0, 1) ? 0 : $urandom_range(17, 31));
        else reg_write(REG_BITS, $urandom_range(1, 16));
        reg_write(REG_AUTO, $urandom_range(0, 1));
        pick_point(REG_BLACK);
        pick_point(REG_WHITE);
    endtask

    // one frame: loads, stray early fetches, then a short, full or overrun read-out
    task automatic run_frame(input bit mid_change);
        int          style, nfetch, half, n;
        int unsigned base;
        style = $urandom_range(0, 3);
        base  = $urandom_range(0, 65535);
        half  = $urandom_range(1, 40);
        n     = 0;
        do begin
            if ($urandom_range(0, 15) == 0) send(OP_FETCH, SAMPLE_W'($urandom));
            send(OP_LOAD, pick_sample(style, base));
            n++;
            if (mid_change && n == half && !frame_ready()) begin
                random_levels();
                // width may move mid-frame only while binning is off and stays off
                if (!binned() && r_sum == 0) reg_write(REG_WIDTH, $urandom_range(1, 12));
            end
        end while (!frame_ready());
        if ($urandom_range(0, 4) == 0) nfetch = $urandom_range(0, out_pixels());
        else nfetch = out_pixels() + $urandom_range(0, 2);
        repeat (nfetch) send(OP_FETCH, SAMPLE_W'($urandom));
    endtask

    // ---------------------------------------------------------------------
    // Command driver: presents the head of cmd_q, pops it on accept, inserts
    // random gaps (mostly short, a few long) when gaps are enabled.
    // ---------------------------------------------------------------------
    int gap_left = 0;

    always @(posedge i_clk) begin
        bit   took;
        bit   nxt_start;
        cmd_t head;
        if (!i_rst_n) begin
            start        <= 1'b0;
            i_opcode     <= OP_LOAD;
            i_raw_sample <= '0;
            gap_left     <= 0;
        end else begin
            took      = start && !busy;
            nxt_start = start && !took;
            if (took) begin
                void'(cmd_q.pop_front());
                if (gaps_on) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2: gap_left <= $urandom_range(1, 3);
                        3:       gap_left <= $urandom_range(10, 40);
                        default: gap_left <= 0;
                    endcase
                end
            end
            if (!nxt_start) begin
                if (!took && gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (!(took && gaps_on && gap_left == 0 && 1'b0) && cmd_q.size() != 0
                             && !(took && gaps_on)) begin
                    head         = cmd_q[0];
                    nxt_start    = 1'b1;
                    i_opcode     <= head.op;
                    i_raw_sample <= head.raw;
                end
            end
            start <= nxt_start;
        end
    end

    // ---------------------------------------------------------------------
    // Result monitor: every strobe must match the oldest expected pixel.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        pix_exp_t e;
        if (i_rst_n && o_result_valid) begin
            if (pix_exp_q.size() == 0) begin
                $error("unexpected pixel beat: pixel %0d", o_pixel);
                fail_count++;
            end else begin
                e = pix_exp_q.pop_front();
                if (o_pixel !== e.pix) begin
                    $error("pixel: expected %0d, got %0d", e.pix, o_pixel);
                    fail_count++;
                end
                if (o_last_pixel !== e.last) begin
                    $error("last_pixel: expected %0d, got %0d", e.last, o_last_pixel);
                    fail_count++;
                end
                if (o_saturated !== e.sat) begin
                    $error("saturated: expected %0d, got %0d", e.sat, o_saturated);
                    fail_count++;
                end
                if (o_stretch_low !== e.lo) begin
                    $error("stretch_low: expected %0d, got %0d", e.lo, o_stretch_low);
                    fail_count++;
                end
                if (o_stretch_high !== e.hi) begin
                    $error("stretch_high: expected %0d, got %0d", e.hi, o_stretch_high);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no beat of any kind
    int quiet_cyc = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid || psel) begin
            quiet_cyc <= 0;
        end else if (quiet_cyc >= WD_LIMIT) begin
            $display("frame_contrast_stretch_bin2x2 test failed");
            $finish;
        end else begin
            quiet_cyc <= quiet_cyc + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    initial begin
        int unsigned w, h;
        int          sel;
        i_rst_n = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        // predictor reset state
        col_cnt = 0; row_cnt = 0; rd_ptr = 0;
        run_min = 32'h3FFFF; run_max = 0;
        lim_lo = 0; lim_hi = 1; sat_flag = 1'b0;
        r_width = 512; r_height = 512; r_shift = 0; r_bits = 16;
        r_sum = 0; r_auto = 1; r_black = 0; r_white = 65536;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: fetch before any frame gives nothing
        send(OP_FETCH, 16'hFFFF);
        // 2x2 raw frame, auto limits, rails in the data, one overrun fetch
        reg_write(REG_WIDTH, 2);
        reg_write(REG_HEIGHT, 2);
        send(OP_LOAD, 16'h0000);
        send(OP_FETCH, 16'h0000);            // frame still open
        send(OP_LOAD, 16'hFFFF);
        send(OP_LOAD, 16'h0001);
        send(OP_LOAD, 16'h8000);
        repeat (5) send(OP_FETCH, 16'h0000);
        // binned 3x3: odd edge dropped, full-scale sums saturate
        reg_write(REG_WIDTH, 3);
        reg_write(REG_HEIGHT, 3);
        reg_write(REG_SUM, 1);
        repeat (9) send(OP_LOAD, 16'hFFFF);
        repeat (2) send(OP_FETCH, 16'h0000);
        // flat frame in manual mode with shift, clamped points
        reg_write(REG_SUM, 0);
        reg_write(REG_WIDTH, 1);
        reg_write(REG_HEIGHT, 1);
        reg_write(REG_SHIFT, 15);
        reg_write(REG_BITS, 1);
        reg_write(REG_AUTO, 0);
        reg_write(REG_BLACK, 131071);
        reg_write(REG_WHITE, 65536);
        send(OP_LOAD, 16'hFFFF);
        send(OP_FETCH, 16'h0000);

        // fill the low store entries that binned sums may later add into
        reg_write(REG_WIDTH, 8);
        reg_write(REG_HEIGHT, 8);
        do send(OP_LOAD, SAMPLE_W'($urandom));
        while (!frame_ready());
        repeat (64) send(OP_LOAD, SAMPLE_W'($urandom));

        // random frames
        while (items_sent < TARGET) begin
            wait_quiet();
            gaps_on = ($urandom_range(0, 3) != 0);
            sel = $urandom_range(0, 49);
            if (sel == 0) begin
                w = 1023; h = 1;            // width saturates to the maximum
            end else if (sel == 1) begin
                w = 1; h = 1023;            // height saturates
            end else begin
                w = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
                h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
            end
            reg_write(REG_WIDTH, w);
            reg_write(REG_HEIGHT, h);
            reg_write(REG_SUM, $urandom_range(0, 1));
            random_levels();
            run_frame($urandom_range(0, 7) == 0);
        end

        wait_quiet();
        if (pix_exp_q.size() != 0) begin
            $error("%0d expected pixels never arrived", pix_exp_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("frame_contrast_stretch_bin2x2 test passed");
        end else begin
            $display("frame_contrast_stretch_bin2x2 test failed");
        end
        $finish;
    end

endmodule
